@@ sv/bole_pkg.sv @@
// Shared constants, codes and types for the bounded ordered list engine.
package bole_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int MAX_RESULTS  = 16;

   localparam logic [2:0] CMD_APPEND      = 3'd0;
   localparam logic [2:0] CMD_REMOVE_HEAD = 3'd1;
   localparam logic [2:0] CMD_REMOVE_TAIL = 3'd2;
   localparam logic [2:0] CMD_REMOVE_POS  = 3'd3;
   localparam logic [2:0] CMD_REMOVE_VAL  = 3'd4;
   localparam logic [2:0] CMD_DUMP        = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_LOAD   = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef logic signed [31:0] elem_type;

   typedef struct packed {
      logic [1:0] op;
      elem_type   key;
   } cell_ctl_type;

endpackage

@@ sv/bole_ifs.sv @@
// Request and response channel interfaces of the list engine.
interface bole_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          command;
   logic signed [31:0]  operand_value;
   logic [4:0]          position;

   modport source(output valid, output command, output operand_value, output position,
                  input ready);
   modport sink(input valid, input command, input operand_value, input position,
                output ready);
endinterface

interface bole_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic signed [31:0]  element_value;
   logic [3:0]          element_index;
   logic [4:0]          length;
   logic                last;

   modport source(output valid, output status, output element_value, output element_index,
                  output length, output last, input ready);
   modport sink(input valid, input status, input element_value, input element_index,
                input length, input last, output ready);
endinterface

@@ sv/bounded_ordered_list_engine_unit.sv @@
// Top level of the bounded ordered list engine: control, fill count and the cell row.
//
// Keeps up to CAPACITY signed 32-bit values packed in a row of cells, head in cell 0.
// Every edit has an accept cycle, in which each cell compares its value with the search
// key, followed in the next cycle by an execute cycle that shifts or loads the row and
// issues the single response. A dump rotates the row once per element, only while the
// response slot is free, emitting the head value each step; when CAPACITY exceeds
// MAX_RESULTS only the first MAX_RESULTS elements are reported, but the row still
// rotates fully to restore its order. Unused command codes are taken and dropped.
// Entries are not cleared at reset; fill count, state, step and response valid are.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bole_req_if.sink    req_bus,
   bole_rsp_if.source  rsp_bus
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [2:0]        cmd_ff;
   elem_type          key_ff;
   logic [4:0]        pos_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   elem_type          rsp_value_ff;
   logic [3:0]        rsp_index_ff;
   logic [4:0]        rsp_length_ff;
   logic              rsp_last_ff;

   logic              accept, out_free, out_load;
   logic [1:0]        out_status;
   elem_type          out_value;
   logic [31:0]       out_index_w, out_length_w;
   logic              out_last;

   cell_ctl_type                     ctl;
   logic [IDX_W-1:0]                 edit_idx;
   elem_type [CAPACITY-1:0]          cell_value;
   logic [CAPACITY-1:0]              cell_match;

   logic [IDX_W-1:0]  first_idx;
   logic              found;
   elem_type          sel_value;
   logic [31:0]       pos_dec_w, tail_w, n_w, step_w;
   logic              pos_bad;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      elem_type nbr;
      if (i < CAPACITY - 1) begin : g_mid
         assign nbr = cell_value[i+1];
      end else begin : g_end
         assign nbr = cell_value[0];
      end
      bole_cell #(.CAPACITY(CAPACITY), .CELL_IDX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .edit_idx   (edit_idx),
         .fill_count (count_ff),
         .next_value (nbr),
         .head_value (cell_value[0]),
         .value      (cell_value[i]),
         .match      (cell_match[i])
      );
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign found = |cell_match;

   always_comb begin
      first_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i]) first_idx = IDX_W'(i);
      end
   end

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (IDX_W'(i) == edit_idx) sel_value = sel_value | cell_value[i];
      end
   end

   assign pos_dec_w = 32'(pos_ff) - 32'd1;
   assign tail_w    = 32'(count_ff) - 32'd1;
   assign pos_bad   = (pos_ff == 5'd0) || (CMP_W'(pos_ff) > CMP_W'(count_ff));
   assign n_w       = (32'(count_ff) < MAX_RESULTS) ? 32'(count_ff) : MAX_RESULTS;
   assign step_w    = 32'(step_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      ctl.op       = CELL_HOLD;
      ctl.key      = (state_ff == S_IDLE) ? req_bus.operand_value : key_ff;
      edit_idx     = '0;
      out_load     = 1'b0;
      out_status   = ST_OK;
      out_value    = '0;
      out_index_w  = '0;
      out_last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_bus.command <= CMD_DUMP)) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            out_load = 1'b1;
            if (cmd_ff == CMD_APPEND) begin
               if (count_ff == CNT_FULL) begin
                  out_status = ST_FULL;
               end else begin
                  ctl.op   = CELL_LOAD;
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (count_ff == '0) begin
               out_status = ST_EMPTY;
            end else begin
               case (cmd_ff)
                  CMD_REMOVE_HEAD: edit_idx = '0;
                  CMD_REMOVE_TAIL: edit_idx = tail_w[IDX_W-1:0];
                  CMD_REMOVE_POS:  edit_idx = pos_dec_w[IDX_W-1:0];
                  CMD_REMOVE_VAL:  edit_idx = first_idx;
                  default:         edit_idx = '0;
               endcase
               if (cmd_ff == CMD_DUMP) begin
                  out_load = 1'b0;
                  state_in = S_DUMP;
                  step_in  = '0;
               end else if ((cmd_ff == CMD_REMOVE_POS && pos_bad) ||
                            (cmd_ff == CMD_REMOVE_VAL && !found)) begin
                  out_status = ST_MISS;
               end else begin
                  ctl.op      = CELL_SHIFT;
                  count_in    = count_ff - CNT_W'(1);
                  out_value   = sel_value;
                  out_index_w = 32'(edit_idx);
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ctl.op      = CELL_ROTATE;
               out_load    = step_w < MAX_RESULTS;
               out_value   = cell_value[0];
               out_index_w = step_w;
               out_last    = (step_w + 32'd1) == n_w;
               step_in     = step_ff + IDX_W'(1);
               if ((step_w + 32'd1) == 32'(count_ff)) begin
                  state_in = S_IDLE;
                  step_in  = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_length_w = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_bus.command;
         key_ff <= req_bus.operand_value;
         pos_ff <= req_bus.position;
      end
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_value_ff  <= out_value;
         rsp_index_ff  <= out_index_w[3:0];
         rsp_length_ff <= out_length_w[4:0];
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.element_value = rsp_value_ff;
   assign rsp_bus.element_index = rsp_index_ff;
   assign rsp_bus.length        = rsp_length_ff;
   assign rsp_bus.last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fill count above capacity");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> !rsp_valid_ff)
      else $error("execute cycle with response slot occupied");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && cmd_ff == CMD_APPEND && count_ff != CNT_FULL)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the list");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> count_ff == $past(count_ff))
      else $error("dump changed the fill count");

endmodule

@@ sv/bole_cell.sv @@
// One storage cell of the list row: holds an element and compares it with the key.
module bole_cell import bole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CELL_IDX = 0,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   edit_idx,
   input  logic [CNT_W-1:0]   fill_count,
   input  elem_type           next_value,
   input  elem_type           head_value,
   output elem_type           value,
   output logic               match
);

   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_CNT1 = CNT_W'(CELL_IDX + 1);

   elem_type value_ff, value_in;
   logic     match_ff, match_in;
   logic     occupied;

   assign occupied = MY_CNT < fill_count;
   assign match_in = occupied && (value_ff == ctl.key);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_LOAD: begin
            if (MY_CNT == fill_count) value_in = ctl.key;
         end
         CELL_SHIFT: begin
            if (MY_IDX >= edit_idx) value_in = next_value;
         end
         CELL_ROTATE: begin
            if (MY_CNT1 == fill_count) value_in = head_value;
            else if (MY_CNT1 < fill_count) value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

@@ bench/tb_bounded_ordered_list_engine_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bounded ordered list engine: random requests vs. a list model.
module tb_bounded_ordered_list_engine_unit;
   import bole_pkg::*;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         RANDOM_REQS   = 450;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         LONG_HOLD     = 400;
   localparam int         GEN_SIDE      = 0;
   localparam int         CHK_SIDE      = 1;
   localparam logic [2:0] CMD_SPARE_A   = 3'd6;
   localparam logic [2:0] CMD_SPARE_B   = 3'd7;
   localparam elem_type   ELEM_MIN      = 32'sh8000_0000;
   localparam elem_type   ELEM_MAX      = 32'sh7fff_ffff;

   typedef struct packed {
      logic       hold_for_drain;
      logic [2:0] command;
      elem_type   operand_value;
      logic [4:0] position;
   } list_req_type;

   typedef struct packed {
      logic [1:0] status;
      elem_type   element_value;
      logic [3:0] element_index;
      logic [4:0] length;
      logic       last;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bole_req_if req_bus ();
   bole_rsp_if rsp_bus ();

   logic       drv_valid    = 1'b0;
   logic [2:0] drv_command  = CMD_APPEND;
   elem_type   drv_operand  = '0;
   logic [4:0] drv_position = '0;
   logic       sink_ready   = 1'b0;

   assign req_bus.valid         = drv_valid;
   assign req_bus.command       = drv_command;
   assign req_bus.operand_value = drv_operand;
   assign req_bus.position      = drv_position;
   assign rsp_bus.ready         = sink_ready;

   bounded_ordered_list_engine_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // list contents: one copy steers the generator, the other predicts responses
   elem_type     list_cells [2][CAPACITY_DEF];
   int           list_len [2] = '{0, 0};
   list_rsp_type step_rsps [MAX_RESULTS];

   list_req_type pending_reqs [$];
   list_rsp_type expected_rsps [$];

   list_req_type drv_item = '0;
   logic         offering = 1'b0;
   int           burst_left;
   int           gap_left;
   int           produced;
   int           k;
   int           queued_reqs   = 0;
   int           accepted_reqs = 0;

   list_rsp_type want;
   logic [15:0]  stall_pattern = 16'h0;
   int           pattern_age   = 0;
   int           hold_left;
   int           holds_done    = 0;
   logic         next_ready;
   int           rsps_checked  = 0;
   int           status_seen [4] = '{0, 0, 0, 0};

   int           error_count = 0;
   int           cycle_count = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 50) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic list_rsp_type make_rsp(input logic [1:0] status, input elem_type value,
                                             input int index, input int length,
                                             input logic last);
      list_rsp_type r;
      r.status        = status;
      r.element_value = value;
      r.element_index = 4'(index);
      r.length        = 5'(length);
      r.last          = last;
      return r;
   endfunction

   // Applies one request to a list copy; fills step_rsps and returns the response count.
   function automatic int apply_command(input int side, input list_req_type rq);
      int       n;
      int       hit;
      int       shown;
      int       i;
      elem_type taken;
      n   = list_len[side];
      hit = -1;
      if (rq.command > CMD_DUMP) return 0;
      if (rq.command == CMD_APPEND) begin
         if (n >= CAPACITY_DEF) begin
            step_rsps[0] = make_rsp(ST_FULL, '0, 0, n, 1'b1);
         end else begin
            list_cells[side][n] = rq.operand_value;
            list_len[side] = n + 1;
            step_rsps[0] = make_rsp(ST_OK, '0, 0, n + 1, 1'b1);
         end
         return 1;
      end
      if (n == 0) begin
         step_rsps[0] = make_rsp(ST_EMPTY, '0, 0, 0, 1'b1);
         return 1;
      end
      case (rq.command)
         CMD_REMOVE_HEAD: hit = 0;
         CMD_REMOVE_TAIL: hit = n - 1;
         CMD_REMOVE_POS: begin
            if (rq.position != 0 && int'(rq.position) <= n) hit = int'(rq.position) - 1;
         end
         CMD_REMOVE_VAL: begin
            for (i = n - 1; i >= 0; i--)
               if (list_cells[side][i] == rq.operand_value) hit = i;
         end
         default: begin
            shown = (n < MAX_RESULTS) ? n : MAX_RESULTS;
            for (i = 0; i < shown; i++)
               step_rsps[i] = make_rsp(ST_OK, list_cells[side][i], i, n, i + 1 == shown);
            return shown;
         end
      endcase
      if (hit < 0) begin
         step_rsps[0] = make_rsp(ST_MISS, '0, 0, n, 1'b1);
         return 1;
      end
      taken = list_cells[side][hit];
      for (i = hit; i + 1 < n; i++) list_cells[side][i] = list_cells[side][i + 1];
      list_len[side] = n - 1;
      step_rsps[0] = make_rsp(ST_OK, taken, hit, n - 1, 1'b1);
      return 1;
   endfunction

   function automatic elem_type pick_value();
      elem_type v;
      case ($urandom_range(0, 3))
         0: v = elem_type'($urandom_range(0, 15)) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0:       v = ELEM_MIN;
               1:       v = ELEM_MAX;
               2:       v = '0;
               default: v = -1;
            endcase
         end
         default: v = elem_type'($urandom);
      endcase
      return v;
   endfunction

   function automatic elem_type held_value();
      return list_cells[GEN_SIDE][$urandom_range(0, list_len[GEN_SIDE] - 1)];
   endfunction

   function automatic logic [4:0] rand_pos();
      return 5'($urandom_range(0, 31));
   endfunction

   task automatic add_req(input logic [2:0] cmd, input elem_type val, input logic [4:0] pos);
      list_req_type rq;
      rq.hold_for_drain = 1'b0;
      rq.command        = cmd;
      rq.operand_value  = val;
      rq.position       = pos;
      pending_reqs.push_back(rq);
      if (cmd <= CMD_DUMP) queued_reqs++;
      void'(apply_command(GEN_SIDE, rq));
   endtask

   task automatic add_drain_wait();
      list_req_type rq;
      rq = '0;
      rq.hold_for_drain = 1'b1;
      pending_reqs.push_back(rq);
   endtask

   task automatic fill_list();
      int extra;
      extra = $urandom_range(1, 2);
      while (list_len[GEN_SIDE] < CAPACITY_DEF) add_req(CMD_APPEND, pick_value(), rand_pos());
      repeat (extra) add_req(CMD_APPEND, pick_value(), rand_pos());
      add_req(CMD_DUMP, pick_value(), rand_pos());
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         burst_left = 0;
         gap_left = 0;
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            produced = apply_command(CHK_SIDE, drv_item);
            for (k = 0; k < produced; k++) expected_rsps.push_back(step_rsps[k]);
            accepted_reqs++;
            offering = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!offering && pending_reqs.size() > 0) begin
            if (pending_reqs[0].hold_for_drain) begin
               if (expected_rsps.size() == 0) void'(pending_reqs.pop_front());
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               drv_item = pending_reqs.pop_front();
               offering = 1'b1;
            end
         end
         drv_valid    <= offering;
         drv_command  <= drv_item.command;
         drv_operand  <= drv_item.operand_value;
         drv_position <= drv_item.position;
      end
   end

   // response monitor with a rotating stall pattern and two long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         sink_ready <= 1'b0;
      end else begin
         if (sink_ready && rsp_bus.valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response: status %0d value %0d index %0d",
                                         rsp_bus.status, rsp_bus.element_value,
                                         rsp_bus.element_index));
            end else begin
               want = expected_rsps.pop_front();
               rsps_checked++;
               status_seen[want.status]++;
               if (rsp_bus.status !== want.status)
                  report_mismatch($sformatf("rsp %0d status got %0d want %0d", rsps_checked,
                                            rsp_bus.status, want.status));
               if (rsp_bus.element_value !== want.element_value)
                  report_mismatch($sformatf("rsp %0d value got %0d want %0d", rsps_checked,
                                            rsp_bus.element_value, want.element_value));
               if (rsp_bus.element_index !== want.element_index)
                  report_mismatch($sformatf("rsp %0d index got %0d want %0d", rsps_checked,
                                            rsp_bus.element_index, want.element_index));
               if (rsp_bus.length !== want.length)
                  report_mismatch($sformatf("rsp %0d length got %0d want %0d", rsps_checked,
                                            rsp_bus.length, want.length));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("rsp %0d last got %0d want %0d", rsps_checked,
                                            rsp_bus.last, want.last));
            end
         end
         pattern_age++;
         if (pattern_age >= 97) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0:       stall_pattern = 16'h0;
               1:       stall_pattern = 16'($urandom & $urandom);
               default: stall_pattern = 16'($urandom);
            endcase
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         if (hold_left == 0 && holds_done < 2 && accepted_reqs >= 120 + 200 * holds_done) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = !stall_pattern[0];
         end
         sink_ready <= next_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  expected_rsps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int start_count;
      int n;
      int pick;

      // empty list: every removal and a dump report empty
      add_req(CMD_DUMP, pick_value(), rand_pos());
      add_req(CMD_REMOVE_HEAD, pick_value(), rand_pos());
      add_req(CMD_REMOVE_TAIL, pick_value(), rand_pos());
      add_req(CMD_REMOVE_POS, pick_value(), 5'd1);
      add_req(CMD_REMOVE_VAL, ELEM_MIN, rand_pos());
      // tail removal on a single element empties the list
      add_req(CMD_APPEND, ELEM_MIN, rand_pos());
      add_req(CMD_REMOVE_TAIL, pick_value(), rand_pos());
      add_req(CMD_APPEND, ELEM_MIN, rand_pos());
      add_req(CMD_APPEND, ELEM_MAX, rand_pos());
      add_req(CMD_APPEND, -1, rand_pos());
      add_req(CMD_APPEND, 0, rand_pos());
      // bad positions and a missing value
      add_req(CMD_REMOVE_POS, pick_value(), 5'd0);
      add_req(CMD_REMOVE_POS, pick_value(), 5'd5);
      add_req(CMD_REMOVE_POS, pick_value(), 5'd31);
      add_req(CMD_REMOVE_VAL, 12345, rand_pos());
      add_req(CMD_DUMP, pick_value(), rand_pos());
      add_req(CMD_REMOVE_POS, pick_value(), 5'd2);
      add_req(CMD_REMOVE_VAL, -1, rand_pos());
      add_req(CMD_REMOVE_HEAD, pick_value(), rand_pos());
      add_req(CMD_SPARE_A, pick_value(), rand_pos());
      add_req(CMD_SPARE_B, pick_value(), rand_pos());
      add_req(CMD_DUMP, pick_value(), rand_pos());
      add_req(CMD_REMOVE_TAIL, pick_value(), rand_pos());
      add_drain_wait();

      start_count = queued_reqs;
      fill_list();
      while (queued_reqs - start_count < RANDOM_REQS) begin
         case ($urandom_range(0, 9))
            0, 1: fill_list();
            2, 3, 4, 5: begin
               repeat ($urandom_range(4, 12)) begin
                  n = list_len[GEN_SIDE];
                  pick = $urandom_range(0, 9);
                  if (pick <= 3)
                     add_req(CMD_APPEND, pick_value(), rand_pos());
                  else if (pick == 4)
                     add_req(CMD_REMOVE_HEAD, pick_value(), rand_pos());
                  else if (pick == 5)
                     add_req(CMD_REMOVE_TAIL, pick_value(), rand_pos());
                  else if (pick <= 7)
                     add_req(CMD_REMOVE_POS, pick_value(),
                             (n > 0 && $urandom_range(0, 4) != 0) ?
                             5'($urandom_range(1, n)) : rand_pos());
                  else if (pick == 8)
                     add_req(CMD_REMOVE_VAL,
                             (n > 0 && $urandom_range(0, 9) < 7) ? held_value() : pick_value(),
                             rand_pos());
                  else
                     add_req(CMD_DUMP, pick_value(), rand_pos());
               end
            end
            6: begin
               while (list_len[GEN_SIDE] > 0) begin
                  n = list_len[GEN_SIDE];
                  case ($urandom_range(0, 3))
                     0:       add_req(CMD_REMOVE_HEAD, pick_value(), rand_pos());
                     1:       add_req(CMD_REMOVE_TAIL, pick_value(), rand_pos());
                     2:       add_req(CMD_REMOVE_POS, pick_value(), 5'($urandom_range(1, n)));
                     default: add_req(CMD_REMOVE_VAL, held_value(), rand_pos());
                  endcase
               end
               add_req(CMD_REMOVE_HEAD + 3'($urandom_range(0, 3)), pick_value(), rand_pos());
               add_req(CMD_DUMP, pick_value(), rand_pos());
            end
            7: begin
               repeat ($urandom_range(3, 6))
                  add_req(3'($urandom_range(0, 7)), elem_type'($urandom), rand_pos());
            end
            8: begin
               add_req(CMD_DUMP, pick_value(), rand_pos());
               add_drain_wait();
            end
            default: add_req(CMD_DUMP, pick_value(), rand_pos());
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || offering) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests with bursts, stalls and %0d long hold-offs;",
               accepted_reqs, holds_done);
      $display("%0d responses checked; status mix: ok %0d, empty %0d, full %0d, not found %0d",
               rsps_checked, status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
               status_seen[ST_MISS]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bole_pkg.sv
sv/bole_ifs.sv
sv/bole_cell.sv
sv/bounded_ordered_list_engine_unit.sv
bench/tb_bounded_ordered_list_engine_unit.sv
